[sv/mtep_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants of the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam int OUT_TICKS_PER_QUARTER = 768;
	localparam int TIME_W = 32;
	localparam int TPQ_W = 15;
	localparam int NUM_W = TIME_W + $clog2(OUT_TICKS_PER_QUARTER);
	localparam int CNT_W = $clog2(NUM_W);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [TPQ_W-1:0] TPQ_RESET = 15'd96;

	localparam logic [1:0] ACT_BYTE = 2'd0;
	localparam logic [1:0] ACT_TRACK_END = 2'd1;
	localparam logic [1:0] ACT_FILE_END = 2'd2;

	localparam logic KIND_PROGRAM = 1'b0;
	localparam logic KIND_SONG_LEN = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [3:0]        channel;
		logic [7:0]        patch_number;
		logic [TIME_W-1:0] ticks;
	} scale_req_t;

endpackage

`default_nettype wire

[sv/mtep_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_front
// Byte parser: delta times, running status, meta/sysex skip, channel
// messages. Emits a scaling request per program change and per end of file.
// ----------------------------------------------------------------------------
module mtep_front
	import mtep_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [1:0] action,
	input  wire logic [7:0] data_byte,
	output logic            req_push,
	output scale_req_t      req
);

	localparam logic [2:0] PH_DELTA = 3'd0;
	localparam logic [2:0] PH_STATUS = 3'd1;
	localparam logic [2:0] PH_FIRST = 3'd2;
	localparam logic [2:0] PH_META_LEN = 3'd3;
	localparam logic [2:0] PH_SYSEX_LEN = 3'd4;
	localparam logic [2:0] PH_SKIP = 3'd5;
	localparam logic [2:0] PH_SECOND = 3'd6;

	localparam logic [7:0] ST_META = 8'hff;
	localparam logic [7:0] ST_SYSEX = 8'hf0;
	localparam logic [7:0] ST_SYSEX_ESC = 8'hf7;
	localparam logic [3:0] TYPE_PROGRAM = 4'hc;
	localparam logic [3:0] TYPE_PRESSURE = 4'hd;

	logic [2:0]        phase_q, phase_d;
	logic [7:0]        status_q, status_d;
	logic [TIME_W-1:0] vlq_q, vlq_d;
	logic [TIME_W-1:0] delta_q, delta_d;
	logic [TIME_W-1:0] skip_q, skip_d;
	logic [6:0]        sxlow_q, sxlow_d;
	logic [TIME_W-1:0] track_q, track_d;
	logic [TIME_W-1:0] longest_q, longest_d;

	logic [TIME_W-1:0] vlq_new;
	logic [TIME_W-1:0] done_time;
	logic [TIME_W-1:0] fold_time;
	logic [TIME_W-1:0] skip_len;
	logic              do_skip;
	logic              do_finish;
	logic              do_clear;
	logic              do_first;

	assign vlq_new = {vlq_q[TIME_W-8:0], data_byte[6:0]};
	assign done_time = track_q + delta_q;
	assign fold_time = (track_q > longest_q) ? track_q : longest_q;

	always_comb begin
		phase_d = phase_q;
		status_d = status_q;
		vlq_d = vlq_q;
		delta_d = delta_q;
		skip_d = skip_q;
		sxlow_d = sxlow_q;
		track_d = track_q;
		longest_d = longest_q;
		req_push = 1'b0;
		req = '0;
		skip_len = '0;
		do_skip = 1'b0;
		do_finish = 1'b0;
		do_clear = 1'b0;
		do_first = 1'b0;

		if (accept) begin
			case (action)
				ACT_TRACK_END: begin
					longest_d = fold_time;
					track_d = '0;
					status_d = '0;
					do_clear = 1'b1;
				end
				ACT_FILE_END: begin
					req_push = 1'b1;
					req.kind = KIND_SONG_LEN;
					req.ticks = fold_time;
					longest_d = '0;
					track_d = '0;
					status_d = '0;
					do_clear = 1'b1;
				end
				ACT_BYTE: begin
					case (phase_q)
						PH_DELTA: begin
							vlq_d = vlq_new;
							if (!data_byte[7]) begin
								delta_d = vlq_new;
								phase_d = PH_STATUS;
							end
						end
						PH_STATUS: begin
							if (data_byte[7]) begin
								status_d = data_byte;
								phase_d = PH_FIRST;
							end else begin
								do_first = 1'b1;
							end
						end
						PH_FIRST: do_first = 1'b1;
						PH_META_LEN: begin
							vlq_d = vlq_new;
							if (!data_byte[7]) begin
								do_skip = 1'b1;
								skip_len = vlq_new;
							end
						end
						PH_SYSEX_LEN: begin
							vlq_d = vlq_new;
							if (!data_byte[7]) begin
								do_skip = 1'b1;
								skip_len = {vlq_new[TIME_W-9:0], 1'b0, sxlow_q};
							end
						end
						PH_SKIP: begin
							skip_d = skip_q - 1'b1;
							if (skip_q == TIME_W'(1)) do_finish = 1'b1;
						end
						PH_SECOND: do_finish = 1'b1;
						default: do_clear = 1'b1;
					endcase

					if (do_first) begin
						if (status_q == ST_META) begin
							vlq_d = '0;
							phase_d = PH_META_LEN;
						end else if (status_q == ST_SYSEX || status_q == ST_SYSEX_ESC) begin
							if (data_byte[7]) begin
								sxlow_d = data_byte[6:0];
								vlq_d = '0;
								phase_d = PH_SYSEX_LEN;
							end else begin
								do_skip = 1'b1;
								skip_len = TIME_W'(data_byte);
							end
						end else if (status_q[7:4] == TYPE_PROGRAM) begin
							do_finish = 1'b1;
							req_push = 1'b1;
							req.kind = KIND_PROGRAM;
							req.channel = status_q[3:0];
							req.patch_number = data_byte;
							req.ticks = done_time;
						end else if (status_q[7:4] == TYPE_PRESSURE) begin
							do_finish = 1'b1;
						end else begin
							phase_d = PH_SECOND;
						end
					end

					if (do_skip) begin
						if (skip_len == '0) begin
							do_finish = 1'b1;
						end else begin
							skip_d = skip_len;
							phase_d = PH_SKIP;
						end
					end

					if (do_finish) begin
						track_d = done_time;
						do_clear = 1'b1;
					end
				end
				default: ;
			endcase

			if (do_clear) begin
				phase_d = PH_DELTA;
				vlq_d = '0;
				delta_d = '0;
				skip_d = '0;
				sxlow_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			status_q <= '0;
			vlq_q <= '0;
			delta_q <= '0;
			skip_q <= '0;
			sxlow_q <= '0;
			track_q <= '0;
			longest_q <= '0;
		end else begin
			phase_q <= phase_d;
			status_q <= status_d;
			vlq_q <= vlq_d;
			delta_q <= delta_d;
			skip_q <= skip_d;
			sxlow_q <= sxlow_d;
			track_q <= track_d;
			longest_q <= longest_d;
		end
	end

endmodule

`default_nettype wire

[sv/mtep_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_queue
// Small FIFO of scaling requests between parser and scaler.
// ----------------------------------------------------------------------------
module mtep_queue
	import mtep_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire scale_req_t  push_req,
	input  wire logic        pop,
	output scale_req_t       head,
	output logic             full,
	output logic             empty
);

	scale_req_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/mtep_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_back
// Time scaler: multiplies by the output resolution, divides by the file
// division one quotient bit per cycle, and holds the result word.
// ----------------------------------------------------------------------------
module mtep_back
	import mtep_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [TPQ_W-1:0]  tpq,
	input  wire scale_req_t        head,
	input  wire logic              empty,
	output logic                   pop,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic                   kind,
	output logic [3:0]             channel,
	output logic [7:0]             patch_number,
	output logic [TIME_W-1:0]      scaled_time
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV = 2'd1;
	localparam logic [1:0] S_OUT = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [TPQ_W-1:0]  rem_q;
	logic [TPQ_W-1:0]  div_q;
	logic              kind_q;
	logic [3:0]        channel_q;
	logic [7:0]        patch_q;
	logic [TIME_W-1:0] time_q;

	logic [TPQ_W:0]    rem_sh;
	logic              rem_ge;
	logic [TPQ_W:0]    rem_sub;
	logic [NUM_W-1:0]  quot;

	assign pop = (state_q == S_IDLE) && !empty;
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, div_q});
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign quot = {num_q[NUM_W-2:0], rem_ge};

	assign out_valid = (state_q == S_OUT);
	assign kind = kind_q;
	assign channel = channel_q;
	assign patch_number = patch_q;
	assign scaled_time = time_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (!empty) begin
					num_q <= NUM_W'(head.ticks) * NUM_W'(OUT_TICKS_PER_QUARTER);
					rem_q <= '0;
					div_q <= (tpq == '0) ? TPQ_W'(1) : tpq;
					kind_q <= head.kind;
					channel_q <= head.channel;
					patch_q <= head.patch_number;
				end
			end
			S_DIV: begin
				num_q <= quot;
				rem_q <= rem_ge ? rem_sub[TPQ_W-1:0] : rem_sh[TPQ_W-1:0];
				if (cnt_q == '0) time_q <= quot[TIME_W-1:0] + TIME_W'(kind_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						state_q <= S_DIV;
						cnt_q <= CNT_W'(NUM_W - 1);
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/midi_track_event_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Standard MIDI file track parser reporting program changes and song length.
// ----------------------------------------------------------------------------
// The parser takes one word per cycle while in_stall is low: track bytes,
// end of track and end of file. Each program change and each end of file
// queues a scaling request (four entries); the scaler takes one request at a
// time: it loads it, divides time*768 by ticks_per_quarter bit-serially and
// holds the result word while out_stall is high. in_stall rises only while
// the request queue is full. ticks_per_quarter resets to 96; the user must
// write it only while the block is idle, which the block does not enforce.
module midi_track_event_parser
	import mtep_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [TPQ_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        action,
	input  wire logic [7:0]        data_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   kind,
	output logic [3:0]             channel,
	output logic [7:0]             patch_number,
	output logic [TIME_W-1:0]      scaled_time
);

	logic [TPQ_W-1:0] tpq_q;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	scale_req_t       push_req;
	scale_req_t       head;
	logic             accept;

	assign in_stall = q_full;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpq_q <= TPQ_RESET;
		end else if (cfg_wr_en) begin
			tpq_q <= cfg_wr_data;
		end
	end

	mtep_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.data_byte (data_byte),
		.req_push  (q_push),
		.req       (push_req)
	);

	mtep_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_req (push_req),
		.pop      (q_pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	mtep_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tpq          (tpq_q),
		.head         (head),
		.empty        (q_empty),
		.pop          (q_pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.kind         (kind),
		.channel      (channel),
		.patch_number (patch_number),
		.scaled_time  (scaled_time)
	);

endmodule

`default_nettype wire

[sv/mtep_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_checker
// Port-level checks of the MIDI track event parser.
// ----------------------------------------------------------------------------
module mtep_checker
	import mtep_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic              kind,
	input wire logic [3:0]        channel,
	input wire logic [7:0]        patch_number,
	input wire logic [TIME_W-1:0] scaled_time
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(channel)
			&& $stable(patch_number) && $stable(scaled_time))
		else $error("stalled result word changed");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result word withdrawn");

	a_song_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SONG_LEN |-> channel == 4'd0 && patch_number == 8'd0)
		else $error("song length word carries channel or patch");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall without a prior accepted word");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kind         (kind),
	.channel      (channel),
	.patch_number (patch_number),
	.scaled_time  (scaled_time)
);

`default_nettype wire
